@@ rtl/masked_3d_laplacian_stencil_top_defines.svh @@
// ----------------------------------------------------------------------------
// masked 3d laplacian stencil assertion macros
// shared assertion forms for the stencil rtl
// ----------------------------------------------------------------------------
`ifndef MASKED_3D_LAPLACIAN_STENCIL_TOP_DEFINES_SVH
`define MASKED_3D_LAPLACIAN_STENCIL_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MLS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mls_pkg.sv @@
// ----------------------------------------------------------------------------
// mls_pkg
// shared types, codes and constants of the masked 3d laplacian stencil
// ----------------------------------------------------------------------------
package mls_pkg;

  localparam int DEF_MAX_SLOW = 64;
  localparam int DEF_MAX_MID  = 64;
  localparam int DEF_MAX_FAST = 64;
  localparam int DEF_SIZE     = 64;

  localparam int VAL_W      = 24;
  localparam int LAB_W      = 2;
  localparam int SIZE_W     = 7;
  localparam int WGT_W      = 16;
  localparam int WSUM_W     = 21;  // 26 weights of 16 bits
  localparam int ACC_W      = 46;
  localparam int NUM_W      = ACC_W + 1;
  localparam int DEN_W      = WSUM_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 5;
  localparam int QCNT_W     = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [STEP_W-1:0] LAST_ISSUE = STEP_W'(26);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(28);

  localparam logic [WGT_W-1:0] DEF_FACE_WEIGHT   = 16'd3430;
  localparam logic [WGT_W-1:0] DEF_EDGE_WEIGHT   = 16'd2426;
  localparam logic [WGT_W-1:0] DEF_CORNER_WEIGHT = 16'd1981;

  localparam logic [WSUM_W-1:0] INSIDE_DIVISOR = WSUM_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_SLOW,
    REG_SIZE_MID,
    REG_SIZE_FAST,
    REG_FACE_WEIGHT,
    REG_EDGE_WEIGHT,
    REG_CORNER_WEIGHT
  } cfg_reg_t;

  localparam logic CMD_VOXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [LAB_W-1:0] LAB_OUTSIDE  = 2'd0;
  localparam logic [LAB_W-1:0] LAB_INSIDE   = 2'd1;
  localparam logic [LAB_W-1:0] LAB_BOUNDARY = 2'd2;

  localparam logic [1:0] CLS_ZERO     = 2'd0;
  localparam logic [1:0] CLS_INSIDE   = 2'd1;
  localparam logic [1:0] CLS_BOUNDARY = 2'd2;
  localparam logic [1:0] CLS_EMPTY    = 2'd3;

  localparam logic [1:0] ORD_FACE   = 2'd1;
  localparam logic [1:0] ORD_EDGE   = 2'd2;

  // window walk: centre first, then the 26 neighbours
  // each entry holds {slow, mid, fast} offset codes, 0 is -1, 1 is 0, 2 is +1
  localparam logic [5:0] NB_TABLE [27] = '{
    6'h15, 6'h00, 6'h01, 6'h02, 6'h04, 6'h05, 6'h06, 6'h08, 6'h09,
    6'h0A, 6'h10, 6'h11, 6'h12, 6'h14, 6'h16, 6'h18, 6'h19, 6'h1A,
    6'h20, 6'h21, 6'h22, 6'h24, 6'h25, 6'h26, 6'h28, 6'h29, 6'h2A
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_PREP,
    ST_NUM,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              start;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              prep;
    logic              num;
    logic              div_step;
    logic              load;
  } cmd_t;

  typedef struct packed {
    logic emit_due;
    logic need_div;
    logic out_blocked;
  } sts_t;

  function automatic int clamp_size(logic [SIZE_W-1:0] v, int hi);
    int r;
    r = int'(v);
    if (r < 3) r = 3;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

@@ rtl/mls_ctrl.sv @@
// ----------------------------------------------------------------------------
// mls_ctrl
// sequencer: take item, walk the window, divide when needed, hand off the result
// ----------------------------------------------------------------------------
`include "masked_3d_laplacian_stencil_top_defines.svh"

module mls_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output mls_pkg::cmd_t cmd,
  input  mls_pkg::sts_t sts
);
  import mls_pkg::*;

  state_t              state, state_next;
  logic [STEP_W-1:0]   step, step_next;
  logic [QCNT_W-1:0]   qcnt, qcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      qcnt  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      qcnt  <= qcnt_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    qcnt_next  = qcnt;
    s_tready   = 1'b0;
    cmd        = '0;
    cmd.step   = step;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        step_next = '0;
        if (sts.emit_due) begin
          cmd.start  = 1'b1;
          state_next = ST_READ;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.issue = (step <= LAST_ISSUE);
        step_next = step + STEP_W'(1);
        if (step == LAST_STEP) begin
          state_next = sts.need_div ? ST_PREP : ST_FINISH;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        cmd.num    = 1'b1;
        qcnt_next  = QCNT_W'(NUM_W - 1);
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        qcnt_next    = qcnt - QCNT_W'(1);
        if (qcnt == '0) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_blocked) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `MLS_ASSERT_IMPL(a_load_unblocked, cmd.load, !sts.out_blocked, "result loaded over a held one")
  `MLS_ASSERT_IMPL(a_step_range, state == ST_READ, step <= LAST_STEP, "window walk overran")

endmodule

@@ rtl/mls_dp.sv @@
// ----------------------------------------------------------------------------
// mls_dp
// volume store, window accumulation, divider and result register
// ----------------------------------------------------------------------------
`include "masked_3d_laplacian_stencil_top_defines.svh"

module mls_dp #(
  parameter int MAX_SLOW = mls_pkg::DEF_MAX_SLOW,
  parameter int MAX_MID  = mls_pkg::DEF_MAX_MID,
  parameter int MAX_FAST = mls_pkg::DEF_MAX_FAST
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mls_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [mls_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mls_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [1:0]                        m_tuser,
  output logic                              m_tlast,
  input  mls_pkg::cmd_t                     cmd,
  output mls_pkg::sts_t                     sts
);
  import mls_pkg::*;

  localparam int PLANE_D = MAX_MID * MAX_FAST;
  localparam int DEPTH   = 3 * PLANE_D;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(MAX_SLOW + 2);
  localparam int MW      = $clog2(MAX_MID + 1);
  localparam int FW      = $clog2(MAX_FAST + 1);
  localparam int PL_W    = $clog2(PLANE_D + 1);
  localparam int CNT_W   = $clog2(MAX_SLOW * PLANE_D + PLANE_D + MAX_FAST + 2);
  localparam int RST_S   = clamp_size(SIZE_W'(DEF_SIZE), MAX_SLOW);
  localparam int RST_M   = clamp_size(SIZE_W'(DEF_SIZE), MAX_MID);
  localparam int RST_F   = clamp_size(SIZE_W'(DEF_SIZE), MAX_FAST);

  // configuration
  logic [SIZE_W-1:0] size_slow, size_mid, size_fast;
  logic [WGT_W-1:0]  face_w, edge_w, corner_w;
  logic [SW-1:0]     sz_s;
  logic [MW-1:0]     sz_m;
  logic [FW-1:0]     sz_f;
  logic [PL_W-1:0]   plane_r;
  logic [CNT_W-1:0]  total_r, lag_r;
  logic              size_wr;

  assign sz_s = SW'(clamp_size(size_slow, MAX_SLOW));
  assign sz_m = MW'(clamp_size(size_mid, MAX_MID));
  assign sz_f = FW'(clamp_size(size_fast, MAX_FAST));
  assign size_wr = cfg_we && (cfg_index == REG_SIZE_SLOW || cfg_index == REG_SIZE_MID ||
                              cfg_index == REG_SIZE_FAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_slow <= SIZE_W'(DEF_SIZE);
      size_mid  <= SIZE_W'(DEF_SIZE);
      size_fast <= SIZE_W'(DEF_SIZE);
      face_w    <= DEF_FACE_WEIGHT;
      edge_w    <= DEF_EDGE_WEIGHT;
      corner_w  <= DEF_CORNER_WEIGHT;
      plane_r   <= PL_W'(RST_M * RST_F);
      total_r   <= CNT_W'(RST_S * RST_M * RST_F);
      lag_r     <= CNT_W'(RST_M * RST_F + RST_F + 1);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE_SLOW:     size_slow <= cfg_data[SIZE_W-1:0];
          REG_SIZE_MID:      size_mid  <= cfg_data[SIZE_W-1:0];
          REG_SIZE_FAST:     size_fast <= cfg_data[SIZE_W-1:0];
          REG_FACE_WEIGHT:   face_w    <= cfg_data;
          REG_EDGE_WEIGHT:   edge_w    <= cfg_data;
          REG_CORNER_WEIGHT: corner_w  <= cfg_data;
          default: ;
        endcase
      end
      plane_r <= PL_W'(sz_m * sz_f);
      total_r <= CNT_W'(sz_s * plane_r);
      lag_r   <= CNT_W'(plane_r) + CNT_W'(sz_f) + CNT_W'(1);
    end
  end

  // scan and emit positions
  logic [CNT_W-1:0] scan_cnt, emit_cnt;
  logic [SW-1:0]    ss, es;
  logic [MW-1:0]    sm, em;
  logic [FW-1:0]    sf, ef;
  logic [1:0]       srp, erp;
  logic             emit_wrap;

  assign emit_wrap = (emit_cnt + CNT_W'(1)) >= total_r;

  always_ff @(posedge clk) begin
    if (rst || size_wr || (cmd.load && emit_wrap)) begin
      scan_cnt <= '0;
      ss <= '0; sm <= '0; sf <= '0; srp <= '0;
      emit_cnt <= '0;
      es <= '0; em <= '0; ef <= '0; erp <= '0;
    end else begin
      if (cmd.accept) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
        if (sf == sz_f - FW'(1)) begin
          sf <= '0;
          if (sm == sz_m - MW'(1)) begin
            sm  <= '0;
            ss  <= ss + SW'(1);
            srp <= (srp == 2'd2) ? 2'd0 : srp + 2'd1;
          end else begin
            sm <= sm + MW'(1);
          end
        end else begin
          sf <= sf + FW'(1);
        end
      end
      if (cmd.load) begin
        emit_cnt <= emit_cnt + CNT_W'(1);
        if (ef == sz_f - FW'(1)) begin
          ef <= '0;
          if (em == sz_m - MW'(1)) begin
            em  <= '0;
            es  <= es + SW'(1);
            erp <= (erp == 2'd2) ? 2'd0 : erp + 2'd1;
          end else begin
            em <= em + MW'(1);
          end
        end else begin
          ef <= ef + FW'(1);
        end
      end
    end
  end

  assign sts.emit_due = (emit_cnt < total_r) &&
                        ({1'b0, scan_cnt} > {1'b0, emit_cnt} + {1'b0, lag_r});

  // volume store: value and label of the last three planes
  logic [VAL_W+LAB_W-1:0] mem [DEPTH];
  logic [VAL_W+LAB_W-1:0] rd_data, wr_data;
  logic [AW-1:0]          waddr, raddr;

  assign wr_data = (s_tuser == CMD_DRAIN) ? '0 : s_tdata[VAL_W+LAB_W-1:0];
  assign waddr = AW'(PLANE_D) * AW'(srp) + AW'(MAX_FAST) * AW'(sm) + AW'(sf);

  // neighbour address for the current walk step
  logic [5:0]    code;
  logic [1:0]    cs, cm, cf, nrp, order;
  logic [MW-1:0] nm;
  logic [FW-1:0] nf;
  logic          nb_ok;

  always_comb begin
    code  = (cmd.step <= LAST_ISSUE) ? NB_TABLE[cmd.step] : 6'h15;
    cs    = code[5:4];
    cm    = code[3:2];
    cf    = code[1:0];
    nb_ok = (cs != 2'd0 || es != '0) &&
            (cs != 2'd2 || ({1'b0, es} + (SW+1)'(1)) < {1'b0, sz_s}) &&
            (cm != 2'd0 || em != '0) &&
            (cm != 2'd2 || ({1'b0, em} + (MW+1)'(1)) < {1'b0, sz_m}) &&
            (cf != 2'd0 || ef != '0) &&
            (cf != 2'd2 || ({1'b0, ef} + (FW+1)'(1)) < {1'b0, sz_f});
    nm    = (cm == 2'd0) ? em - MW'(1) : (cm == 2'd2) ? em + MW'(1) : em;
    nf    = (cf == 2'd0) ? ef - FW'(1) : (cf == 2'd2) ? ef + FW'(1) : ef;
    if (cs == 2'd0)      nrp = (erp == 2'd0) ? 2'd2 : erp - 2'd1;
    else if (cs == 2'd2) nrp = (erp == 2'd2) ? 2'd0 : erp + 2'd1;
    else                 nrp = erp;
    order = 2'((cs != 2'd1)) + 2'((cm != 2'd1)) + 2'((cf != 2'd1));
    raddr = AW'(PLANE_D) * AW'(nrp) + AW'(MAX_FAST) * AW'(nm) + AW'(nf);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && scan_cnt < total_r) mem[waddr] <= wr_data;
    if (cmd.issue) rd_data <= mem[raddr];
  end

  // accumulation pipeline: read, weight, add
  logic                    t1_valid, t1_centre, t1_ok;
  logic [1:0]              t1_order;
  logic signed [VAL_W-1:0] rd_val, centre_val;
  logic [LAB_W-1:0]        rd_lab, centre_lab;
  logic [WGT_W-1:0]        wsel;
  logic signed [WGT_W:0]   wgt_s;
  logic signed [VAL_W+WGT_W:0] mul;
  logic                    use_nb, prod_use;
  logic signed [ACC_W-1:0] prod, acc;
  logic [WSUM_W-1:0]       wsum;

  assign rd_val = signed'(rd_data[VAL_W-1:0]);
  assign rd_lab = rd_data[VAL_W+LAB_W-1:VAL_W];
  assign wsel   = (t1_order == ORD_FACE) ? face_w : (t1_order == ORD_EDGE) ? edge_w : corner_w;
  assign wgt_s  = signed'({1'b0, wsel});
  assign mul    = rd_val * wgt_s;
  assign use_nb = t1_valid && !t1_centre && t1_ok &&
                  (centre_lab != LAB_BOUNDARY || rd_lab == LAB_BOUNDARY);

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      t1_valid <= 1'b0;
      prod_use <= 1'b0;
      acc      <= '0;
      wsum     <= '0;
    end else begin
      t1_valid <= cmd.issue;
      prod_use <= use_nb;
      if (use_nb) wsum <= wsum + WSUM_W'(wsel);
      if (prod_use) acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    t1_centre <= (cmd.step == '0);
    t1_ok     <= nb_ok;
    t1_order  <= order;
    prod      <= {{(ACC_W-VAL_W-WGT_W-1){mul[VAL_W+WGT_W]}}, mul};
    if (t1_valid && t1_centre) begin
      centre_val <= rd_val;
      centre_lab <= rd_lab;
    end
  end

  // classification of the centre voxel
  logic interior;
  logic [1:0] cls;

  assign interior = (es != '0) && ({1'b0, es} + (SW+1)'(1)) < {1'b0, sz_s} &&
                    (em != '0) && ({1'b0, em} + (MW+1)'(1)) < {1'b0, sz_m} &&
                    (ef != '0) && ({1'b0, ef} + (FW+1)'(1)) < {1'b0, sz_f};

  always_comb begin
    if (centre_lab == LAB_INSIDE)        cls = interior ? CLS_INSIDE : CLS_ZERO;
    else if (centre_lab == LAB_BOUNDARY) cls = (wsum != '0) ? CLS_BOUNDARY : CLS_EMPTY;
    else                                 cls = CLS_ZERO;
  end

  assign sts.need_div = (cls == CLS_INSIDE) || (cls == CLS_BOUNDARY);

  // rounded division, one quotient bit a cycle
  logic [WSUM_W-1:0]       divisor;
  logic signed [WSUM_W:0]  div_s;
  logic signed [ACC_W-1:0] cmul, prod2, nval;
  logic [ACC_W-1:0]        mag;
  logic                    neg;
  logic [NUM_W-1:0]        num;
  logic [DEN_W-1:0]        den, rem;
  logic [DEN_W:0]          rem_s;

  assign divisor = (centre_lab == LAB_INSIDE) ? INSIDE_DIVISOR : wsum;
  assign div_s   = signed'({1'b0, divisor});
  assign cmul    = centre_val * div_s;
  assign nval    = prod2 - acc;
  assign mag     = nval[ACC_W-1] ? ACC_W'(-nval) : ACC_W'(nval);
  assign rem_s   = {rem, num[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.prep) prod2 <= cmul;
    if (cmd.num) begin
      neg <= nval[ACC_W-1];
      num <= {mag, 1'b0} + NUM_W'(divisor);
      den <= {divisor, 1'b0};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_s >= {1'b0, den}) begin
        rem <= DEN_W'(rem_s - {1'b0, den});
        num <= {num[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_s[DEN_W-1:0];
        num <= {num[NUM_W-2:0], 1'b0};
      end
    end
  end

  // saturation and result register
  logic [VAL_W-1:0] sat;

  always_comb begin
    if (!neg) sat = (num > NUM_W'(24'h7FFFFF)) ? 24'h7FFFFF : num[VAL_W-1:0];
    else      sat = (num > NUM_W'(25'h0800000)) ? 24'h800000 : VAL_W'(24'd0 - num[VAL_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= sts.need_div ? sat : '0;
      m_tuser <= cls;
      m_tlast <= (emit_cnt + CNT_W'(1)) == total_r;
    end
  end

  assign sts.out_blocked = m_tvalid && !m_tready;

  `MLS_ASSERT_IMPL(a_emit_bound, 1'b1, emit_cnt < total_r, "emit position past volume end")
  `MLS_ASSERT_NEXT(a_load_shows, cmd.load, m_tvalid, "loaded result not presented")

endmodule

@@ rtl/masked_3d_laplacian_stencil_top.sv @@
// ----------------------------------------------------------------------------
// masked_3d_laplacian_stencil_top
// masked 26-neighbour 3d laplacian over a raster-scanned voxel stream
// an item producing no result is only accepted and checked; one that reports a voxel
// also walks the window, and divides as well when the centre needs a division
// the 27 window reads share the single store read port, one a cycle, and the
// radix-2 divider retires one of its 47 quotient bits a cycle
// a result trails its voxel by size_mid*size_fast+size_fast+1 items
// reset restores default sizes and weights, clears positions and handshakes; the store is not cleared
// ----------------------------------------------------------------------------
module masked_3d_laplacian_stencil_top #(
  parameter int MAX_SLOW = mls_pkg::DEF_MAX_SLOW,
  parameter int MAX_MID  = mls_pkg::DEF_MAX_MID,
  parameter int MAX_FAST = mls_pkg::DEF_MAX_FAST
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [mls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mls_pkg::CFG_DATA_W-1:0] cfg_data,
  // voxel item stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mls_pkg::IN_DATA_W-1:0]  s_tdata,   // voxel_value[23:0], mask_label[25:24]
  input  logic                           s_tuser,   // command
  // result item stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mls_pkg::OUT_DATA_W-1:0] m_tdata,   // laplacian[23:0]
  output logic [1:0]                     m_tuser,   // voxel_class
  output logic                           m_tlast    // last_voxel
);
  import mls_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: one item at a time, walks the window then divides when needed
  mls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: store, accumulate, divide, output register
  mls_dp #(
    .MAX_SLOW (MAX_SLOW),
    .MAX_MID  (MAX_MID),
    .MAX_FAST (MAX_FAST)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
